@@ src/ofn_pkg.sv @@
// Shared constants, types and helper functions for the opening angle function.
`timescale 1ns / 1ps
package ofn_pkg;

  localparam int ANG_W  = 15;  // Q2.13 angle and opening width
  localparam int EXP_W  = 16;  // Q4.12 exponent width
  localparam int FRAC_W = 16;  // fraction bits of a Q16.16 exponent
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int TDATA_W = 16;

  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LOW_ANGLE    = 3'd0,
    REG_MID_ANGLE    = 3'd1,
    REG_HIGH_ANGLE   = 3'd2,
    REG_LOW_OPENING  = 3'd3,
    REG_MID_OPENING  = 3'd4,
    REG_HIGH_OPENING = 3'd5,
    REG_LOW_EXP      = 3'd6,
    REG_HIGH_EXP     = 3'd7
  } reg_idx_t;

  // per-item flags that ride along the pipeline
  typedef struct packed {
    logic             bypass;   // result is a constant opening
    logic [ANG_W-1:0] byp_val;
    logic             hi;       // angle above the middle threshold
    logic             xzero;    // normalized distance is zero
    logic             kzero;    // blend base is zero
    logic             kone;     // blend base is one
  } side_t;

  typedef logic [31:0] root_tab_t [FRAC_W];

  // floor square root of a 64-bit value
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      b = 64'd1 << (2 * k);
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // 2^(-2^-(i+1)) in Q0.32, by repeated square roots of one half
  function automatic root_tab_t build_roots();
    root_tab_t tab;
    logic [63:0] s;
    s = isqrt64(64'h8000_0000_0000_0000);
    tab[0] = s[31:0];
    for (int i = 1; i < FRAC_W; i++) begin
      s = isqrt64({tab[i-1], 32'b0});
      tab[i] = s[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

  // rounded product by log2(e), Q16.16 result
  function automatic logic [32:0] mul_log2e(input logic [31:0] p);
    logic [63:0] prod;
    prod = {32'b0, p} * {33'b0, LOG2E_Q30} + 64'h2000_0000;
    return prod[62:30];
  endfunction

endpackage

@@ src/ofn_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module ofn_div import ofn_pkg::*; #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [DW-1:0] den_r [NW];
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [SW-1:0] sd_r  [NW];

  logic          pv   [NW];
  logic [NW-1:0] pnum [NW];
  logic [DW-1:0] pden [NW];
  logic [DW-1:0] prem [NW];
  logic [NW-1:0] pquo [NW];
  logic [SW-1:0] psd  [NW];

  for (genvar j = 0; j < NW; j++) begin : g_st
    logic [DW:0]   cand;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_n;

    // stage inputs
    if (j == 0) begin : g_first
      assign pv[j]   = in_valid;
      assign pnum[j] = in_num;
      assign pden[j] = in_den;
      assign prem[j] = '0;
      assign pquo[j] = '0;
      assign psd[j]  = in_side;
    end else begin : g_next
      assign pv[j]   = vld_r[j-1];
      assign pnum[j] = num_r[j-1];
      assign pden[j] = den_r[j-1];
      assign prem[j] = rem_r[j-1];
      assign pquo[j] = quo_r[j-1];
      assign psd[j]  = sd_r[j-1];
    end

    // shift in one dividend bit, subtract when it fits
    always_comb begin
      cand  = {prem[j], pnum[j][NW-1]};
      ge    = cand >= {1'b0, pden[j]};
      diff  = cand - {1'b0, pden[j]};
      rem_n = ge ? diff[DW-1:0] : cand[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= pv[j];
      end
      if (en) begin
        num_r[j] <= pnum[j] << 1;
        den_r[j] <= pden[j];
        rem_r[j] <= rem_n;
        quo_r[j] <= {pquo[j][NW-2:0], ge};
        sd_r[j]  <= psd[j];
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quo   = quo_r[NW-1];
  assign out_side  = sd_r[NW-1];

endmodule

@@ src/ofn_exp2.sv @@
// Pipelined 2^-z for a nonnegative Q16.16 exponent, Q0.32 result.
`timescale 1ns / 1ps
module ofn_exp2 import ofn_pkg::*; #(
  parameter int ZW = 33,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [ZW-1:0] in_z,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [32:0]   out_r,
  output logic [SW-1:0] out_side
);

  localparam int ST = FRAC_W;

  logic          vld_r [ST];
  logic [32:0]   r_r   [ST];
  logic [ZW-1:0] z_r   [ST];
  logic [SW-1:0] sd_r  [ST];

  logic          pv  [ST];
  logic [32:0]   pr  [ST];
  logic [ZW-1:0] pz  [ST];
  logic [SW-1:0] psd [ST];

  logic          fv_r;
  logic [32:0]   fr_r;
  logic [SW-1:0] fsd_r;
  logic          big;
  logic [32:0]   shifted;

  for (genvar i = 0; i < ST; i++) begin : g_st
    logic [63:0] prod;
    logic [32:0] nr;

    if (i == 0) begin : g_first
      assign pv[i]  = in_valid;
      assign pr[i]  = ONE_Q32;
      assign pz[i]  = in_z;
      assign psd[i] = in_side;
    end else begin : g_next
      assign pv[i]  = vld_r[i-1];
      assign pr[i]  = r_r[i-1];
      assign pz[i]  = z_r[i-1];
      assign psd[i] = sd_r[i-1];
    end

    // rounded product by 2^(-2^-(i+1)) when this fraction bit is set
    always_comb begin
      prod = {32'b0, pr[i][31:0]} * {32'b0, ROOT_TAB[i]} + 64'h8000_0000;
      if (!pz[i][FRAC_W-1-i]) begin
        nr = pr[i];
      end else if (pr[i][32]) begin
        nr = {1'b0, ROOT_TAB[i]};
      end else begin
        nr = {1'b0, prod[63:32]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= pv[i];
      end
      if (en) begin
        r_r[i]  <= nr;
        z_r[i]  <= pz[i];
        sd_r[i] <= psd[i];
      end
    end
  end

  // integer part: right shift, zero at 32 or more
  assign big     = (z_r[ST-1] >> (FRAC_W + 5)) != '0;
  assign shifted = r_r[ST-1] >> z_r[ST-1][FRAC_W+4:FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= vld_r[ST-1];
    end
    if (en) begin
      fr_r  <= big ? 33'd0 : shifted;
      fsd_r <= sd_r[ST-1];
    end
  end

  assign out_valid = fv_r;
  assign out_r     = fr_r;
  assign out_side  = fsd_r;

endmodule

@@ src/opening_angle_function.sv @@
// Top level of the opening angle function pipeline with its register port.
`timescale 1ns / 1ps
// Opening angle function: one angle in, one opening angle out.
//  in_*  : stream of angles, tdata[14:0] = angle (unsigned Q2.13 radians).
//  out_* : stream of results, tdata[14:0] = opening (unsigned Q2.13).
//  cfg_* : register port, eight registers at byte addresses 0, 4, .. 28;
//          write only while no transaction is in flight.
// Throughput: one transaction per cycle, with no gaps, while the receiver is not stalling.
// An accepted input reaches out_tvalid through the three pipelined dividers
// (31, 32 and 48 stages, one quotient bit each), three 17-stage exp2 units,
// a 5-stage normalizer and a 16-stage log2.
// The whole pipeline advances when the output register is empty or
// being taken; when the receiver stalls every stage holds and in_tready
// drops in the same cycle, so nothing is lost or repeated.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// registers with their default thresholds, openings and exponents.
// Angles at or below low_angle give low_opening, at or above high_angle
// give high_opening; between them the result blends from mid_opening.
module opening_angle_function import ofn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [14:0] angle
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [14:0] opening
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output logic [DATA_W-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int SW     = $bits(side_t);
  localparam int XNW    = ANG_W + FRAC_W;
  localparam int NRM_ST = 5;
  localparam int SQ_ST  = FRAC_W;

  // ---------------- configuration registers ----------------
  logic [ANG_W-1:0] low_ang_r, mid_ang_r, high_ang_r;
  logic [ANG_W-1:0] low_op_r, mid_op_r, high_op_r;
  logic [EXP_W-1:0] low_exp_r, high_exp_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_ang_r  <= 15'd0;
      mid_ang_r  <= 15'd12868;
      high_ang_r <= 15'd25736;
      low_op_r   <= 15'd0;
      mid_op_r   <= 15'd6434;
      high_op_r  <= 15'd12868;
      low_exp_r  <= 16'd4096;
      high_exp_r <= 16'd4096;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LOW_ANGLE:    low_ang_r  <= cfg_pwdata[ANG_W-1:0];
        REG_MID_ANGLE:    mid_ang_r  <= cfg_pwdata[ANG_W-1:0];
        REG_HIGH_ANGLE:   high_ang_r <= cfg_pwdata[ANG_W-1:0];
        REG_LOW_OPENING:  low_op_r   <= cfg_pwdata[ANG_W-1:0];
        REG_MID_OPENING:  mid_op_r   <= cfg_pwdata[ANG_W-1:0];
        REG_HIGH_OPENING: high_op_r  <= cfg_pwdata[ANG_W-1:0];
        REG_LOW_EXP:      low_exp_r  <= cfg_pwdata[EXP_W-1:0];
        REG_HIGH_EXP:     high_exp_r <= cfg_pwdata[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_LOW_ANGLE:    cfg_prdata = {17'b0, low_ang_r};
      REG_MID_ANGLE:    cfg_prdata = {17'b0, mid_ang_r};
      REG_HIGH_ANGLE:   cfg_prdata = {17'b0, high_ang_r};
      REG_LOW_OPENING:  cfg_prdata = {17'b0, low_op_r};
      REG_MID_OPENING:  cfg_prdata = {17'b0, mid_op_r};
      REG_HIGH_OPENING: cfg_prdata = {17'b0, high_op_r};
      REG_LOW_EXP:      cfg_prdata = {16'b0, low_exp_r};
      REG_HIGH_EXP:     cfg_prdata = {16'b0, high_exp_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------- global stall ----------------
  logic             en;
  logic             out_v_r;
  logic [ANG_W-1:0] out_res_r;

  assign en         = !out_v_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_res_r};

  // ---------------- stage 0: classify the angle ----------------
  logic [ANG_W-1:0] ang;
  logic [ANG_W-1:0] num0, den0;
  side_t            sd0;
  logic             s0_v_r;
  logic [ANG_W-1:0] s0_num_r, s0_den_r;
  side_t            s0_sd_r;

  assign ang = in_tdata[ANG_W-1:0];

  always_comb begin
    sd0  = '0;
    num0 = '0;
    den0 = '0;
    if (ang <= low_ang_r) begin
      sd0.bypass  = 1'b1;
      sd0.byp_val = low_op_r;
    end else if (ang >= high_ang_r) begin
      sd0.bypass  = 1'b1;
      sd0.byp_val = high_op_r;
    end else if (ang <= mid_ang_r) begin
      num0 = mid_ang_r - ang;
      den0 = mid_ang_r - low_ang_r;
    end else begin
      sd0.hi = 1'b1;
      num0   = ang - mid_ang_r;
      den0   = high_ang_r - mid_ang_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
    if (en) begin
      s0_num_r <= num0;
      s0_den_r <= den0;
      s0_sd_r  <= sd0;
    end
  end

  // ---------------- x = num * 2^16 / den ----------------
  logic           xv;
  logic [XNW-1:0] xq;
  logic [SW-1:0]  xsd_raw;
  side_t          xsd;

  ofn_div #(.NW(XNW), .DW(ANG_W), .SW(SW)) u_div_x (
    .clk, .rst_n, .en,
    .in_valid (s0_v_r),
    .in_num   ({s0_num_r, 16'b0}),
    .in_den   (s0_den_r),
    .in_side  (SW'(s0_sd_r)),
    .out_valid(xv),
    .out_quo  (xq),
    .out_side (xsd_raw)
  );
  assign xsd = side_t'(xsd_raw);

  // ---------------- p = (1 - x) / x ----------------
  logic [16:0] x17;
  logic [16:0] one_mx;
  logic        xz;
  side_t       psd_in;
  logic        pv;
  logic [31:0] pq;
  logic [SW-1:0] psd_raw;

  assign x17    = xq[16:0];
  assign xz     = (x17 == '0);
  assign one_mx = 17'h10000 - x17;
  always_comb begin
    psd_in       = xsd;
    psd_in.xzero = xz;
  end

  ofn_div #(.NW(32), .DW(17), .SW(SW)) u_div_p (
    .clk, .rst_n, .en,
    .in_valid (xv),
    .in_num   ({one_mx[15:0], 16'b0}),
    .in_den   (xz ? 17'd1 : x17),
    .in_side  (SW'(psd_in)),
    .out_valid(pv),
    .out_quo  (pq),
    .out_side (psd_raw)
  );

  // ---------------- p * log2(e) ----------------
  logic          m1_v_r;
  logic [32:0]   m1_z_r;
  logic [SW-1:0] m1_sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= pv;
    end
    if (en) begin
      m1_z_r  <= mul_log2e(pq);
      m1_sd_r <= psd_raw;
    end
  end

  // ---------------- e1 = 2^-z ----------------
  logic          e1v;
  logic [32:0]   e1;
  logic [SW-1:0] e1sd_raw;

  ofn_exp2 #(.ZW(33), .SW(SW)) u_exp_1 (
    .clk, .rst_n, .en,
    .in_valid (m1_v_r),
    .in_z     (m1_z_r),
    .in_side  (m1_sd_r),
    .out_valid(e1v),
    .out_r    (e1),
    .out_side (e1sd_raw)
  );

  // ---------------- q = e1 / (1 - e1) ----------------
  logic        e1one;
  logic [32:0] dq;
  side_t       qsd_in;
  logic        qv;
  logic [47:0] qq;
  logic [SW-1:0] qsd_raw;

  assign e1one = e1[32];
  assign dq    = ONE_Q32 - e1;
  always_comb begin
    qsd_in      = side_t'(e1sd_raw);
    qsd_in.kone = e1one;
  end

  ofn_div #(.NW(48), .DW(33), .SW(SW)) u_div_q (
    .clk, .rst_n, .en,
    .in_valid (e1v),
    .in_num   ({e1[31:0], 16'b0}),
    .in_den   (e1one ? 33'd1 : dq),
    .in_side  (SW'(qsd_in)),
    .out_valid(qv),
    .out_quo  (qq),
    .out_side (qsd_raw)
  );

  // ---------------- capped q * log2(e) ----------------
  logic [31:0]   q32;
  logic          m2_v_r;
  logic [32:0]   m2_z_r;
  logic [SW-1:0] m2_sd_r;

  assign q32 = (qq[47:32] != '0) ? 32'hFFFF_FFFF : qq[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= qv;
    end
    if (en) begin
      m2_z_r  <= mul_log2e(q32);
      m2_sd_r <= qsd_raw;
    end
  end

  // ---------------- e2 = 2^-z, k = 1 - e2 ----------------
  logic          e2v;
  logic [32:0]   e2;
  logic [SW-1:0] e2sd_raw;

  ofn_exp2 #(.ZW(33), .SW(SW)) u_exp_2 (
    .clk, .rst_n, .en,
    .in_valid (m2_v_r),
    .in_z     (m2_z_r),
    .in_side  (m2_sd_r),
    .out_valid(e2v),
    .out_r    (e2),
    .out_side (e2sd_raw)
  );

  logic        k_v_r;
  logic [31:0] k_m_r;
  side_t       k_sd_r;
  logic [32:0] k_full;
  side_t       ksd_n;

  assign k_full = ONE_Q32 - e2;
  always_comb begin
    ksd_n       = side_t'(e2sd_raw);
    ksd_n.kzero = ksd_n.xzero || (!ksd_n.kone && e2 == ONE_Q32);
    ksd_n.kone  = ksd_n.kone || (e2 == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_v_r <= 1'b0;
    end else if (en) begin
      k_v_r <= e2v;
    end
    if (en) begin
      k_m_r  <= k_full[31:0];
      k_sd_r <= ksd_n;
    end
  end

  // ---------------- -log2(k): normalize ----------------
  logic        nv_r [NRM_ST];
  logic [31:0] nm_r [NRM_ST];
  logic [4:0]  ne_r [NRM_ST];
  side_t       ns_r [NRM_ST];
  logic        pnv  [NRM_ST];
  logic [31:0] pnm  [NRM_ST];
  logic [4:0]  pne  [NRM_ST];
  side_t       pns  [NRM_ST];

  for (genvar s = 0; s < NRM_ST; s++) begin : g_nrm
    localparam int SH = 1 << (NRM_ST - 1 - s);
    logic [31:0] m_n;
    logic [4:0]  e_n;

    if (s == 0) begin : g_first
      assign pnv[s] = k_v_r;
      assign pnm[s] = k_m_r;
      assign pne[s] = '0;
      assign pns[s] = k_sd_r;
    end else begin : g_next
      assign pnv[s] = nv_r[s-1];
      assign pnm[s] = nm_r[s-1];
      assign pne[s] = ne_r[s-1];
      assign pns[s] = ns_r[s-1];
    end

    // shift up by SH when the top SH bits are clear
    always_comb begin
      if (pnm[s][31 -: SH] == '0) begin
        m_n = pnm[s] << SH;
        e_n = pne[s] + 5'(SH);
      end else begin
        m_n = pnm[s];
        e_n = pne[s];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[s] <= 1'b0;
      end else if (en) begin
        nv_r[s] <= pnv[s];
      end
      if (en) begin
        nm_r[s] <= m_n;
        ne_r[s] <= e_n;
        ns_r[s] <= pns[s];
      end
    end
  end

  // ---------------- -log2(k): squaring, one fraction bit each ----------------
  logic        sv_r [SQ_ST];
  logic [31:0] sm_r [SQ_ST];
  logic [15:0] sf_r [SQ_ST];
  logic [4:0]  se_r [SQ_ST];
  side_t       ss_r [SQ_ST];
  logic        psv  [SQ_ST];
  logic [31:0] psm  [SQ_ST];
  logic [15:0] psf  [SQ_ST];
  logic [4:0]  pse  [SQ_ST];
  side_t       pss  [SQ_ST];

  for (genvar i = 0; i < SQ_ST; i++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    logic [31:0] m_n;
    logic [15:0] f_n;

    if (i == 0) begin : g_first
      assign psv[i] = nv_r[NRM_ST-1];
      assign psm[i] = nm_r[NRM_ST-1];
      assign psf[i] = '0;
      assign pse[i] = ne_r[NRM_ST-1];
      assign pss[i] = ns_r[NRM_ST-1];
    end else begin : g_next
      assign psv[i] = sv_r[i-1];
      assign psm[i] = sm_r[i-1];
      assign psf[i] = sf_r[i-1];
      assign pse[i] = se_r[i-1];
      assign pss[i] = ss_r[i-1];
    end

    always_comb begin
      sq  = {32'b0, psm[i]} * {32'b0, psm[i]};
      t   = sq[63:31];
      f_n = psf[i];
      if (t[32]) begin
        f_n[SQ_ST-1-i] = 1'b1;
        m_n = t[32:1];
      end else begin
        m_n = t[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i] <= 1'b0;
      end else if (en) begin
        sv_r[i] <= psv[i];
      end
      if (en) begin
        sm_r[i] <= m_n;
        sf_r[i] <= f_n;
        se_r[i] <= pse[i];
        ss_r[i] <= pss[i];
      end
    end
  end

  // ---------------- z3 = -log2(k) * w ----------------
  logic [5:0]       e_p1;
  logic [21:0]      lg;
  logic [EXP_W-1:0] w_sel;
  logic [37:0]      lw;
  logic             lw_v_r;
  logic [25:0]      lw_z_r;
  side_t            lw_sd_r;

  assign e_p1  = {1'b0, se_r[SQ_ST-1]} + 6'd1;
  assign lg    = {e_p1, 16'b0} - {6'b0, sf_r[SQ_ST-1]};
  assign w_sel = ss_r[SQ_ST-1].hi ? high_exp_r : low_exp_r;
  assign lw    = {16'b0, lg} * {22'b0, w_sel} + 38'd2048;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else if (en) begin
      lw_v_r <= sv_r[SQ_ST-1];
    end
    if (en) begin
      lw_z_r  <= lw[37:12];
      lw_sd_r <= ss_r[SQ_ST-1];
    end
  end

  // ---------------- a = 2^-z3 ----------------
  logic          e3v;
  logic [32:0]   e3;
  logic [SW-1:0] e3sd_raw;
  side_t         e3sd;

  ofn_exp2 #(.ZW(26), .SW(SW)) u_exp_3 (
    .clk, .rst_n, .en,
    .in_valid (lw_v_r),
    .in_z     (lw_z_r),
    .in_side  (SW'(lw_sd_r)),
    .out_valid(e3v),
    .out_r    (e3),
    .out_side (e3sd_raw)
  );
  assign e3sd = side_t'(e3sd_raw);

  // ---------------- weight select and scaled magnitude ----------------
  logic [EXP_W-1:0] w_a;
  logic [32:0]      a_w;
  logic [ANG_W-1:0] side_op;
  logic             up;
  logic [ANG_W-1:0] diff;
  logic [47:0]      mag_prod;
  logic             a_v_r;
  logic [ANG_W-1:0] a_mag_r;
  logic             a_up_r;
  side_t            a_sd_r;

  assign w_a     = e3sd.hi ? high_exp_r : low_exp_r;
  assign side_op = e3sd.hi ? high_op_r : low_op_r;
  assign up      = side_op >= mid_op_r;
  assign diff    = up ? side_op - mid_op_r : mid_op_r - side_op;

  always_comb begin
    if (w_a == '0) begin
      a_w = ONE_Q32;
    end else if (e3sd.kzero) begin
      a_w = '0;
    end else if (e3sd.kone) begin
      a_w = ONE_Q32;
    end else begin
      a_w = e3;
    end
  end

  assign mag_prod = {15'b0, a_w} * {33'b0, diff} + 48'h8000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= e3v;
    end
    if (en) begin
      a_mag_r <= mag_prod[46:32];
      a_up_r  <= up;
      a_sd_r  <= e3sd;
    end
  end

  // ---------------- output register ----------------
  logic [ANG_W:0]   sum;
  logic [ANG_W-1:0] res;

  assign sum = {1'b0, mid_op_r} + {1'b0, a_mag_r};
  always_comb begin
    if (a_sd_r.bypass) begin
      res = a_sd_r.byp_val;
    end else if (a_up_r) begin
      res = sum[ANG_W] ? '1 : sum[ANG_W-1:0];
    end else begin
      res = mid_op_r - a_mag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= a_v_r;
    end
    if (en) begin
      out_res_r <= res;
    end
  end

  // ---------------- assertions ----------------
  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    xv && !xsd.bypass |-> xq <= 31'd65536)
    else $error("normalized distance above one");

  a_e1_range: assert property (@(posedge clk) disable iff (!rst_n)
    e1v |-> e1 <= ONE_Q32)
    else $error("exp2 result above one");

  a_norm_msb: assert property (@(posedge clk) disable iff (!rst_n)
    nv_r[NRM_ST-1] && !ns_r[NRM_ST-1].bypass && !ns_r[NRM_ST-1].kzero &&
    !ns_r[NRM_ST-1].kone |-> nm_r[NRM_ST-1][31])
    else $error("log2 operand not normalized");

endmodule
